// ===== hdl/lisc_pkg.sv =====
// Shared types and constants for the LAPD I-frame sequence control block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package lisc_pkg;

	localparam int SEQ_W      = 7;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef logic [SEQ_W-1:0]      seq_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Register index, taken from paddr word address
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TEI_ASSIGNED = 2'd0;
	localparam reg_idx_t REG_OWN_TEI      = 2'd1;
	localparam reg_idx_t REG_WINDOW_SIZE  = 2'd2;

	localparam logic MODE_RX = 1'b0;
	localparam logic MODE_TX = 1'b1;

	typedef enum logic [1:0] {
		LINK_MULTIFR = 2'd0,
		LINK_TIMREC  = 2'd1,
		LINK_AW_EST  = 2'd2,
		LINK_OTHER   = 2'd3
	} link_state_t;

	typedef enum logic [1:0] {
		RESP_NONE = 2'd0,
		RESP_RR   = 2'd1,
		RESP_RNR  = 2'd2,
		RESP_REJ  = 2'd3
	} resp_t;

	typedef enum logic [1:0] {
		T200_NONE    = 2'd0,
		T200_STOP    = 2'd1,
		T200_RESTART = 2'd2,
		T200_START   = 2'd3
	} t200_t;

	typedef enum logic [1:0] {
		T203_NONE    = 2'd0,
		T203_RESTART = 2'd1,
		T203_STOP    = 2'd2
	} t203_t;

	typedef enum logic [2:0] {
		REFUSE_NONE        = 3'd0,
		REFUSE_PEER_BUSY   = 3'd1,
		REFUSE_WINDOW_FULL = 3'd2,
		REFUSE_QUEUE_EMPTY = 3'd3,
		REFUSE_DROPPED     = 3'd4
	} refuse_t;

	typedef struct packed {
		logic tei_assigned;
		seq_t own_tei;
		seq_t window_size;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		seq_t        rx_tei;
		seq_t        rx_send_number;
		seq_t        rx_recv_number;
		logic        rx_poll;
		link_state_t link_state;
		logic        own_receiver_busy;
		logic        peer_receiver_busy;
		logic        retrans_timer_idle;
		logic        frame_ready;
	} item_t;

	typedef struct packed {
		logic        deliver;
		resp_t       response_kind;
		logic        response_final;
		seq_t        acked_number;
		t200_t       t200_action;
		t203_t       t203_action;
		link_state_t new_link_state;
		logic        sequence_error;
		logic        tx_iframe;
		seq_t        tx_send_number;
		seq_t        tx_recv_number;
		refuse_t     refuse_reason;
	} result_t;

	// V(S), V(A), V(R) and the reject-exception flag
	typedef struct packed {
		seq_t send;
		seq_t ack;
		seq_t recv;
		logic rej_exc;
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/lisc_cfg_regs.sv =====
// APB-style configuration registers: TEI assignment, own TEI and window size k.
// Depends on lisc_pkg.
`default_nettype none

module lisc_cfg_regs (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic psel,
	input  wire                logic penable,
	input  wire                logic pwrite,
	input  wire lisc_pkg::cfg_addr_t paddr,
	input  wire lisc_pkg::cfg_data_t pwdata,
	output lisc_pkg::cfg_data_t      prdata,
	output logic                     pready,
	output lisc_pkg::cfg_t           cfg
);
	import lisc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tei_assigned <= 1'b0;
			cfg_q.own_tei      <= '0;
			cfg_q.window_size  <= seq_t'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_TEI_ASSIGNED: cfg_q.tei_assigned <= pwdata[0];
				REG_OWN_TEI:      cfg_q.own_tei      <= pwdata[SEQ_W-1:0];
				REG_WINDOW_SIZE:  cfg_q.window_size  <= pwdata[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TEI_ASSIGNED: prdata[0]         = cfg_q.tei_assigned;
			REG_OWN_TEI:      prdata[SEQ_W-1:0] = cfg_q.own_tei;
			REG_WINDOW_SIZE:  prdata[SEQ_W-1:0] = cfg_q.window_size;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/lisc_seq_core.sv =====
// Single-pass sequence logic: one item and the current V(S)/V(A)/V(R) state in,
// one result and the next state out. Purely combinational. Depends on lisc_pkg.
`default_nettype none

module lisc_seq_core (
	input  wire lisc_pkg::cfg_t       cfg,
	input  wire lisc_pkg::seq_state_t st,
	input  wire lisc_pkg::item_t      item,
	output lisc_pkg::result_t         res,
	output lisc_pkg::seq_state_t      st_next
);
	import lisc_pkg::*;

	seq_t d_nr;
	seq_t d_vs;
	logic nr_ok;
	logic tei_ok;
	logic link_ok;

	// N(R) valid when it lies within V(A)..V(S), modulo 128
	assign d_nr    = item.rx_recv_number - st.ack;
	assign d_vs    = st.send - st.ack;
	assign nr_ok   = (d_nr <= d_vs);
	assign tei_ok  = cfg.tei_assigned && (cfg.own_tei == item.rx_tei);
	assign link_ok = (item.link_state == LINK_MULTIFR) || (item.link_state == LINK_TIMREC);

	always_comb begin
		res                = '0;
		st_next            = st;
		res.new_link_state = item.link_state;
		if (item.mode == MODE_RX) begin
			if (!tei_ok || !link_ok) begin
				res.refuse_reason = REFUSE_DROPPED;
			end else begin
				res.acked_number = item.rx_recv_number;
				if (item.own_receiver_busy) begin
					if (item.rx_poll) begin
						res.response_kind  = RESP_RNR;
						res.response_final = 1'b1;
					end
				end else if (item.rx_send_number == st.recv) begin
					st_next.recv       = st.recv + seq_t'(1);
					st_next.rej_exc    = 1'b0;
					res.deliver        = 1'b1;
					res.response_kind  = RESP_RR;
					res.response_final = item.rx_poll;
				end else if (st.rej_exc) begin
					if (item.rx_poll) begin
						res.response_kind  = RESP_RR;
						res.response_final = 1'b1;
					end
				end else begin
					st_next.rej_exc    = 1'b1;
					res.response_kind  = RESP_REJ;
					res.response_final = item.rx_poll;
				end

				if (nr_ok) begin
					if ((item.link_state == LINK_TIMREC) || item.peer_receiver_busy) begin
						st_next.ack = item.rx_recv_number;
					end else if (item.rx_recv_number == st.send) begin
						st_next.ack     = item.rx_recv_number;
						res.t200_action = T200_STOP;
						res.t203_action = T203_RESTART;
					end else if (item.rx_recv_number != st.ack) begin
						st_next.ack     = item.rx_recv_number;
						res.t200_action = T200_RESTART;
					end
				end else begin
					res.sequence_error = 1'b1;
					res.new_link_state = LINK_AW_EST;
				end
			end
		end else begin
			if (item.peer_receiver_busy) begin
				res.refuse_reason = REFUSE_PEER_BUSY;
			end else if (st.send == seq_t'(st.ack + cfg.window_size)) begin
				res.refuse_reason = REFUSE_WINDOW_FULL;
			end else if (!item.frame_ready) begin
				res.refuse_reason = REFUSE_QUEUE_EMPTY;
			end else begin
				res.tx_iframe      = 1'b1;
				res.tx_send_number = st.send;
				res.tx_recv_number = st.recv;
				st_next.send       = st.send + seq_t'(1);
				if (item.retrans_timer_idle) begin
					res.t203_action = T203_STOP;
					res.t200_action = T200_START;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lapd_iframe_sequence_control.sv =====
// Top level of the modulo-128 LAPD I-frame sequence control block.
// Depends on lisc_pkg, lisc_cfg_regs and lisc_seq_core.
`default_nettype none

// Unless stalled, the block takes one item per clock and returns exactly one
// result item for each: a received I-frame header (mode 0) is checked for TEI
// and link state, sequenced against V(R), answered with RR, RNR or REJ, and
// its N(R) checked against V(A)..V(S) to command timers T200 and T203; a
// transmit request (mode 1) sends the next queued frame when the peer is not
// busy and the window k allows, reporting N(S)/N(R) and advancing V(S). The
// input register feeds the sequence logic, which loads the result register;
// the result is held there until out_ready takes it. Sustained rate is one
// item per cycle while out_ready does not stall, set by the single update of
// the V(S)/V(A)/V(R) registers that happens as each item moves into the
// result register. A result waiting on a stalled out_ready does not stop the
// block from taking one more item into the input register. Acknowledgement
// is always immediate, so no ack-pending flag is kept. Configuration
// registers (tei_assigned at 0x0, own_tei at 0x4, window_size at 0x8) may
// only be written while no item is in flight; reset leaves the TEI
// unassigned and k = 1.

module lapd_iframe_sequence_control (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	// configuration port
	input  wire  logic        psel,
	input  wire  logic        penable,
	input  wire  logic        pwrite,
	input  wire  logic [3:0]  paddr,
	input  wire  logic [31:0] pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input items
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic        mode,
	input  wire  logic [6:0]  rx_tei,
	input  wire  logic [6:0]  rx_send_number,
	input  wire  logic [6:0]  rx_recv_number,
	input  wire  logic        rx_poll,
	input  wire  logic [1:0]  link_state,
	input  wire  logic        own_receiver_busy,
	input  wire  logic        peer_receiver_busy,
	input  wire  logic        retrans_timer_idle,
	input  wire  logic        frame_ready,
	// result items
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic              deliver,
	output logic [1:0]        response_kind,
	output logic              response_final,
	output logic [6:0]        acked_number,
	output logic [1:0]        t200_action,
	output logic [1:0]        t203_action,
	output logic [1:0]        new_link_state,
	output logic              sequence_error,
	output logic              tx_iframe,
	output logic [6:0]        tx_send_number,
	output logic [6:0]        tx_recv_number,
	output logic [2:0]        refuse_reason
);
	import lisc_pkg::*;

	cfg_t       cfg;
	item_t      item_in;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_comb;
	result_t    res_s2;
	logic       valid_s2;
	seq_state_t st_q;
	seq_state_t st_next;
	logic       accept_in;
	logic       advance_s1;

	lisc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pack the input item
	always_comb begin
		item_in.mode               = mode;
		item_in.rx_tei             = rx_tei;
		item_in.rx_send_number     = rx_send_number;
		item_in.rx_recv_number     = rx_recv_number;
		item_in.rx_poll            = rx_poll;
		item_in.link_state         = link_state_t'(link_state);
		item_in.own_receiver_busy  = own_receiver_busy;
		item_in.peer_receiver_busy = peer_receiver_busy;
		item_in.retrans_timer_idle = retrans_timer_idle;
		item_in.frame_ready        = frame_ready;
	end

	// Stage 1 moves on whenever the result register is empty or being drained;
	// the input register refills in the same cycle.
	assign advance_s1 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign accept_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= item_in;
		end
	end

	lisc_seq_core u_core (
		.cfg     (cfg),
		.st      (st_q),
		.item    (item_s1),
		.res     (res_comb),
		.st_next (st_next)
	);

	// Commit the sequence state only when the item's result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance_s1) begin
			st_q <= st_next;
		end
	end

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid      = valid_s2;
	assign deliver        = res_s2.deliver;
	assign response_kind  = res_s2.response_kind;
	assign response_final = res_s2.response_final;
	assign acked_number   = res_s2.acked_number;
	assign t200_action    = res_s2.t200_action;
	assign t203_action    = res_s2.t203_action;
	assign new_link_state = res_s2.new_link_state;
	assign sequence_error = res_s2.sequence_error;
	assign tx_iframe      = res_s2.tx_iframe;
	assign tx_send_number = res_s2.tx_send_number;
	assign tx_recv_number = res_s2.tx_recv_number;
	assign refuse_reason  = res_s2.refuse_reason;

	// A pending item in stage 1 is never dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1)
		else $error("stage 1 item lost while stalled");

	// A transmitted frame advances V(S) by exactly one
	a_vs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && res_comb.tx_iframe |=> st_q.send == seq_t'($past(st_q.send) + seq_t'(1)))
		else $error("V(S) did not advance after transmit");

	// V(S) never moves without a transmitted frame
	a_vs_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance_s1 && res_comb.tx_iframe) |=> $stable(st_q.send))
		else $error("V(S) changed without transmit");

	// An N(R) error always reports awaiting establishment
	a_seq_err_link: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.sequence_error |-> res_s2.new_link_state == LINK_AW_EST)
		else $error("sequence error without link state change");

	// Delivery and transmission exclude any refusal
	a_no_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.deliver || res_s2.tx_iframe) |-> res_s2.refuse_reason == REFUSE_NONE)
		else $error("refusal reported with delivered or sent frame");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lapd_iframe_sequence_control: a directed table of frames,
// then random frame traffic checked against a cycle-free model of the sequence state.
// Depends on lisc_pkg and the RTL in hdl/.

module tb;
	import lisc_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic { ROW_FRAME, ROW_REG } row_kind_t;

	// One line of the directed table: either a register write or a frame,
	// the latter with an optional hand-written result
	typedef struct packed {
		row_kind_t kind;
		reg_idx_t  reg_idx;
		cfg_data_t reg_val;
		item_t     frame;
		logic      typed;
		result_t   typed_res;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      psel = 1'b0;
	logic      penable = 1'b0;
	logic      pwrite = 1'b0;
	cfg_addr_t paddr = '0;
	cfg_data_t pwdata = '0;
	wire [31:0] prdata;
	wire        pready;

	logic  in_valid = 1'b0;
	wire   in_ready;
	item_t frame_in = '0;

	logic       out_ready = 1'b0;
	wire        out_valid;
	wire        deliver;
	wire [1:0]  response_kind;
	wire        response_final;
	wire [6:0]  acked_number;
	wire [1:0]  t200_action;
	wire [1:0]  t203_action;
	wire [1:0]  new_link_state;
	wire        sequence_error;
	wire        tx_iframe;
	wire [6:0]  tx_send_number;
	wire [6:0]  tx_recv_number;
	wire [2:0]  refuse_reason;

	// Shadow copy of the registers and of V(S), V(A), V(R), reject exception
	cfg_t link_cfg = {1'b0, 7'd0, 7'd1};
	seq_t tx_seq = '0;
	seq_t ack_seq = '0;
	seq_t rx_seq = '0;
	logic reject_armed = 1'b0;

	result_t   expected_q[$];
	stim_row_t dir_rows[$];
	int        failures = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	bit        hold_req = 1'b0;
	bit        hold_seen = 1'b0;

	lapd_iframe_sequence_control uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (frame_in.mode),
		.rx_tei            (frame_in.rx_tei),
		.rx_send_number    (frame_in.rx_send_number),
		.rx_recv_number    (frame_in.rx_recv_number),
		.rx_poll           (frame_in.rx_poll),
		.link_state        (frame_in.link_state),
		.own_receiver_busy (frame_in.own_receiver_busy),
		.peer_receiver_busy(frame_in.peer_receiver_busy),
		.retrans_timer_idle(frame_in.retrans_timer_idle),
		.frame_ready       (frame_in.frame_ready),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.deliver           (deliver),
		.response_kind     (response_kind),
		.response_final    (response_final),
		.acked_number      (acked_number),
		.t200_action       (t200_action),
		.t203_action       (t203_action),
		.new_link_state    (new_link_state),
		.sequence_error    (sequence_error),
		.tx_iframe         (tx_iframe),
		.tx_send_number    (tx_send_number),
		.tx_recv_number    (tx_recv_number),
		.refuse_reason     (refuse_reason)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out the result of one accepted frame event and advance the shadow state.
	function automatic result_t next_frame_result(input item_t it);
		result_t r;
		seq_t    nr_off;
		seq_t    vs_off;
		seq_t    win_edge;
		r = '0;
		r.new_link_state = it.link_state;
		if (it.mode == MODE_RX) begin
			// drop frames for another TEI, or when no TEI is assigned, or outside
			// multiframe established / timer recovery
			if (!(link_cfg.tei_assigned && link_cfg.own_tei == it.rx_tei) ||
			    (it.link_state != LINK_MULTIFR && it.link_state != LINK_TIMREC)) begin
				r.refuse_reason = REFUSE_DROPPED;
			end else begin
				r.acked_number = it.rx_recv_number;
				// receive side: busy answers RNR on poll, in-sequence frames are
				// delivered, the first out-of-sequence frame arms REJ
				if (it.own_receiver_busy) begin
					if (it.rx_poll) r.response_kind = RESP_RNR;
				end else if (it.rx_send_number == rx_seq) begin
					rx_seq = rx_seq + seq_t'(1);
					reject_armed = 1'b0;
					r.deliver = 1'b1;
					r.response_kind = RESP_RR;
				end else if (reject_armed) begin
					if (it.rx_poll) r.response_kind = RESP_RR;
				end else begin
					reject_armed = 1'b1;
					r.response_kind = RESP_REJ;
				end
				if (r.response_kind != RESP_NONE) r.response_final = it.rx_poll;

				// acknowledge side: N(R) must lie in V(A)..V(S), modulo 128
				nr_off = it.rx_recv_number - ack_seq;
				vs_off = tx_seq - ack_seq;
				if (nr_off <= vs_off) begin
					if (it.link_state == LINK_TIMREC || it.peer_receiver_busy) begin
						ack_seq = it.rx_recv_number;
					end else if (it.rx_recv_number == tx_seq) begin
						ack_seq = it.rx_recv_number;
						r.t200_action = T200_STOP;
						r.t203_action = T203_RESTART;
					end else if (it.rx_recv_number != ack_seq) begin
						ack_seq = it.rx_recv_number;
						r.t200_action = T200_RESTART;
					end
				end else begin
					r.sequence_error = 1'b1;
					r.new_link_state = LINK_AW_EST;
				end
			end
		end else begin
			win_edge = ack_seq + link_cfg.window_size;
			if (it.peer_receiver_busy) begin
				r.refuse_reason = REFUSE_PEER_BUSY;
			end else if (tx_seq == win_edge) begin
				r.refuse_reason = REFUSE_WINDOW_FULL;
			end else if (!it.frame_ready) begin
				r.refuse_reason = REFUSE_QUEUE_EMPTY;
			end else begin
				r.tx_iframe = 1'b1;
				r.tx_send_number = tx_seq;
				r.tx_recv_number = rx_seq;
				tx_seq = tx_seq + seq_t'(1);
				if (it.retrans_timer_idle) begin
					r.t200_action = T200_START;
					r.t203_action = T203_STOP;
				end
			end
		end
		return r;
	endfunction

	// Mostly well-formed traffic: our TEI, N(S) = V(R), N(R) inside the window;
	// the rest is noise that exercises drops, rejects and N(R) errors.
	function automatic item_t random_frame(input int tx_pct, input int ack_hold_pct);
		item_t it;
		seq_t  span;
		span = tx_seq - ack_seq;
		it.mode = ($urandom_range(99) < tx_pct) ? MODE_TX : MODE_RX;
		it.rx_tei = ($urandom_range(9) == 0) ? seq_t'($urandom) : link_cfg.own_tei;
		it.rx_send_number = ($urandom_range(3) == 0) ? seq_t'($urandom) : rx_seq;
		if ($urandom_range(99) < ack_hold_pct) it.rx_recv_number = ack_seq;
		else if ($urandom_range(9) == 0) it.rx_recv_number = seq_t'($urandom);
		else it.rx_recv_number = seq_t'(ack_seq + $urandom_range(span));
		it.rx_poll = 1'($urandom_range(1));
		case ($urandom_range(19))
			0: it.link_state = LINK_AW_EST;
			1: it.link_state = LINK_OTHER;
			2, 3, 4, 5: it.link_state = LINK_TIMREC;
			default: it.link_state = LINK_MULTIFR;
		endcase
		it.own_receiver_busy = ($urandom_range(9) == 0);
		it.peer_receiver_busy = ($urandom_range(7) == 0);
		it.retrans_timer_idle = 1'($urandom_range(1));
		it.frame_ready = ($urandom_range(7) != 0);
		return it;
	endfunction

	function automatic item_t rx_frame(input seq_t tei, input seq_t ns, input seq_t nr,
			input logic poll, input link_state_t ls, input logic obusy, input logic pbusy);
		item_t it;
		it = '0;
		it.mode = MODE_RX;
		it.rx_tei = tei;
		it.rx_send_number = ns;
		it.rx_recv_number = nr;
		it.rx_poll = poll;
		it.link_state = ls;
		it.own_receiver_busy = obusy;
		it.peer_receiver_busy = pbusy;
		return it;
	endfunction

	function automatic item_t tx_req(input link_state_t ls, input logic pbusy,
			input logic t200_idle, input logic fready);
		item_t it;
		it = '0;
		it.mode = MODE_TX;
		it.link_state = ls;
		it.peer_receiver_busy = pbusy;
		it.retrans_timer_idle = t200_idle;
		it.frame_ready = fready;
		return it;
	endfunction

	function automatic result_t refused(input refuse_t why, input link_state_t ls);
		result_t r;
		r = '0;
		r.refuse_reason = why;
		r.new_link_state = ls;
		return r;
	endfunction

	function automatic stim_row_t frame_row(input item_t it);
		stim_row_t row;
		row = '0;
		row.kind = ROW_FRAME;
		row.frame = it;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input item_t it, input result_t res);
		stim_row_t row;
		row = frame_row(it);
		row.typed = 1'b1;
		row.typed_res = res;
		return row;
	endfunction

	function automatic stim_row_t reg_row(input reg_idx_t idx, input cfg_data_t val);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Offer one item: idle a random stretch, then hold valid and the payload
	// until the item is taken, and queue up what it must produce.
	task automatic offer_frame(input item_t it, input logic typed, input result_t typed_res);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_in <= it;
		do @(posedge clk); while (!in_ready);
		predicted = next_frame_result(it);
		expected_q.push_back(typed ? typed_res : predicted);
	endtask

	// Drop valid and wait until every result is back and the pipeline is empty.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle. Only done with the block idle.
	task automatic write_reg(input reg_idx_t idx, input cfg_data_t val);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= cfg_addr_t'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEI_ASSIGNED: link_cfg.tei_assigned = val[0];
			REG_OWN_TEI:      link_cfg.own_tei = val[SEQ_W-1:0];
			REG_WINDOW_SIZE:  link_cfg.window_size = val[SEQ_W-1:0];
			default: ;
		endcase
	endtask

	// With squeeze set, stall the receiver for a long stretch early on so the
	// block backs up into its input, and later let everything drain mid-phase.
	task automatic run_random(input int count, input int tx_pct, input int ack_hold_pct,
			input bit squeeze);
		for (int k = 0; k < count; k++) begin
			if (squeeze && k == 60) hold_req = ~hold_req;
			if (squeeze && k == 200) wait_results_drained();
			offer_frame(random_frame(tx_pct, ack_hold_pct), 1'b0, '0);
		end
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			failures++;
		end
	endtask

	// Receiver: random ready, plus a long hold-off whenever one is requested.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result item with the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		result_t want;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result item with no frame outstanding");
				failures++;
			end else begin
				want = expected_q.pop_front();
				check_field("deliver", want.deliver, deliver);
				check_field("response_kind", want.response_kind, response_kind);
				check_field("response_final", want.response_final, response_final);
				check_field("acked_number", want.acked_number, acked_number);
				check_field("t200_action", want.t200_action, t200_action);
				check_field("t203_action", want.t203_action, t203_action);
				check_field("new_link_state", want.new_link_state, new_link_state);
				check_field("sequence_error", want.sequence_error, sequence_error);
				check_field("tx_iframe", want.tx_iframe, tx_iframe);
				check_field("tx_send_number", want.tx_send_number, tx_send_number);
				check_field("tx_recv_number", want.tx_recv_number, tx_recv_number);
				check_field("refuse_reason", want.refuse_reason, refuse_reason);
			end
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		// Directed table. Out of reset: no TEI, k = 1, all sequence numbers zero.
		dir_rows.push_back(typed_row(rx_frame(7'd0, 7'd0, 7'd0, 1'b1, LINK_MULTIFR, 1'b0,
			1'b0), refused(REFUSE_DROPPED, LINK_MULTIFR)));
		dir_rows.push_back(typed_row(tx_req(LINK_OTHER, 1'b1, 1'b1, 1'b1),
			refused(REFUSE_PEER_BUSY, LINK_OTHER)));
		dir_rows.push_back(typed_row(tx_req(LINK_TIMREC, 1'b0, 1'b1, 1'b0),
			refused(REFUSE_QUEUE_EMPTY, LINK_TIMREC)));
		dir_rows.push_back(reg_row(REG_TEI_ASSIGNED, 32'd1));
		dir_rows.push_back(reg_row(REG_OWN_TEI, 32'd127));
		// wrong TEI, then right TEI in a link state that takes no frames
		dir_rows.push_back(typed_row(rx_frame(7'd126, 7'd0, 7'd0, 1'b1, LINK_MULTIFR, 1'b0,
			1'b0), refused(REFUSE_DROPPED, LINK_MULTIFR)));
		dir_rows.push_back(typed_row(rx_frame(7'd127, 7'd0, 7'd0, 1'b1, LINK_AW_EST, 1'b0,
			1'b0), refused(REFUSE_DROPPED, LINK_AW_EST)));
		dir_rows.push_back(typed_row(rx_frame(7'd127, 7'd0, 7'd0, 1'b1, LINK_OTHER, 1'b0,
			1'b0), refused(REFUSE_DROPPED, LINK_OTHER)));
		// send one frame, then the window of one is full
		dir_rows.push_back(frame_row(tx_req(LINK_MULTIFR, 1'b0, 1'b1, 1'b1)));
		dir_rows.push_back(typed_row(tx_req(LINK_MULTIFR, 1'b0, 1'b1, 1'b1),
			refused(REFUSE_WINDOW_FULL, LINK_MULTIFR)));
		// in-sequence frame acking everything, then REJ, then RR / nothing under
		// the reject exception, then RNR / nothing while busy
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd0, 7'd1, 1'b1, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd5, 7'd1, 1'b0, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd9, 7'd1, 1'b1, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd9, 7'd1, 1'b0, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd1, 7'd1, 1'b1, LINK_MULTIFR, 1'b1,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd1, 7'd1, 1'b0, LINK_MULTIFR, 1'b1,
			1'b0)));
		// N(R) outside V(A)..V(S)
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd1, 7'd100, 1'b0, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(reg_row(REG_WINDOW_SIZE, 32'd127));
		dir_rows.push_back(frame_row(tx_req(LINK_MULTIFR, 1'b0, 1'b0, 1'b1)));
		dir_rows.push_back(frame_row(tx_req(LINK_TIMREC, 1'b0, 1'b1, 1'b1)));
		dir_rows.push_back(frame_row(tx_req(LINK_OTHER, 1'b0, 1'b1, 1'b1)));
		// partial ack restarts T200; timer recovery and peer busy ack silently
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd2, 7'd2, 1'b1, LINK_MULTIFR, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd3, 7'd3, 1'b0, LINK_TIMREC, 1'b0,
			1'b0)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd4, 7'd4, 1'b1, LINK_MULTIFR, 1'b0,
			1'b1)));
		dir_rows.push_back(frame_row(rx_frame(7'd127, 7'd127, 7'd127, 1'b1, LINK_MULTIFR,
			1'b0, 1'b1)));
		dir_rows.push_back(reg_row(REG_OWN_TEI, 32'd0));
		dir_rows.push_back(frame_row(rx_frame(7'd0, 7'd5, 7'd4, 1'b0, LINK_MULTIFR, 1'b0,
			1'b0)));

		// hold reset, then release on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(16, 63);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				offer_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].typed_res);
		end

		// Random phases, each under its own register setting.
		write_reg(REG_TEI_ASSIGNED, 32'd1);
		write_reg(REG_OWN_TEI, 32'd0);
		write_reg(REG_WINDOW_SIZE, 32'd1);
		run_random(250, 40, 20, 1'b0);

		// widest window: hold N(R) back so V(S) runs up to V(A) + 127
		set_idle(63, 16);
		write_reg(REG_OWN_TEI, 32'd127);
		write_reg(REG_WINDOW_SIZE, 32'd127);
		run_random(300, 70, 97, 1'b0);

		set_idle(0, 0);
		write_reg(REG_OWN_TEI, cfg_data_t'($urandom_range(127)));
		write_reg(REG_WINDOW_SIZE, 32'd7);
		run_random(300, 40, 20, 1'b1);

		// a window of zero refuses whenever nothing is outstanding
		set_idle(16, 63);
		write_reg(REG_OWN_TEI, 32'd85);
		write_reg(REG_WINDOW_SIZE, 32'd0);
		run_random(120, 40, 20, 1'b0);

		// TEI withdrawn: every received frame is dropped
		set_idle(63, 16);
		write_reg(REG_TEI_ASSIGNED, 32'd0);
		run_random(80, 40, 20, 1'b0);

		set_idle(0, 0);
		write_reg(REG_TEI_ASSIGNED, 32'd1);
		write_reg(REG_OWN_TEI, cfg_data_t'($urandom_range(127)));
		write_reg(REG_WINDOW_SIZE, cfg_data_t'($urandom_range(126, 2)));
		run_random(450, 45, 40, 1'b0);

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
